// ----- sv/smf_pkg.sv -----
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants for the MIDI file meta text extractor
// Holds the parse phase encoding, stop causes, result record and small
// decode helpers used by the parser and the output stage.
// ----------------------------------------------------------------------------
package smf_pkg;

	typedef enum logic [3:0] {
		PH_HDR    = 4'd0,
		PH_CHDR   = 4'd1,
		PH_DELTA  = 4'd2,
		PH_STATUS = 4'd3,
		PH_MTYPE  = 4'd4,
		PH_MLEN   = 4'd5,
		PH_SXLEN  = 4'd6,
		PH_SKIP   = 4'd7,
		PH_EMIT   = 4'd8,
		PH_TOEND  = 4'd9,
		PH_DONE   = 4'd10,
		PH_HALT   = 4'd11
	} phase_t;

	typedef enum logic [1:0] {
		CAUSE_OK        = 2'd0,
		CAUSE_BAD_HDR   = 2'd1,
		CAUSE_NOT_MTRK  = 2'd2,
		CAUSE_TRUNCATED = 2'd3
	} cause_t;

	typedef enum logic [1:0] {
		KIND_TEXT   = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_MARKER = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ONLY   = 1'd1;

	localparam logic [7:0] STATUS_META   = 8'hFF;
	localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
	localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
	localparam logic [7:0] META_TEXT     = 8'h01;
	localparam logic [7:0] META_NAME     = 8'h03;
	localparam logic [7:0] META_MARKER   = 8'h06;
	localparam logic [7:0] META_EOT      = 8'h2F;
	localparam logic [3:0] HDR_LEN       = 4'd14;

	typedef struct packed {
		logic       payload_valid;
		logic [1:0] meta_kind;
		logic [7:0] payload_byte;
		logic       last_of_event;
		logic       file_done;
		logic [1:0] stop_cause;
	} res_t;

	// "MThd"
	function automatic logic [7:0] file_magic(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0: v = 8'h4D;
			2'd1: v = 8'h54;
			2'd2: v = 8'h68;
			default: v = 8'h64;
		endcase
		return v;
	endfunction

	// "MTrk"
	function automatic logic [7:0] trk_magic(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0: v = 8'h4D;
			2'd1: v = 8'h54;
			2'd2: v = 8'h72;
			default: v = 8'h6B;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] data_count(input logic [7:0] status);
		logic [1:0] n;
		if (status[7:4] == 4'hC || status[7:4] == 4'hD) begin
			n = 2'd1;
		end else begin
			n = 2'd2;
		end
		return n;
	endfunction

	function automatic kind_t kind_of(input logic [7:0] mtype);
		kind_t k;
		case (mtype)
			META_TEXT:   k = KIND_TEXT;
			META_NAME:   k = KIND_NAME;
			META_MARKER: k = KIND_MARKER;
			default:     k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

// ----- sv/smf_parse.sv -----
// ----------------------------------------------------------------------------
// smf_parse: byte-wise parse state and result formation
// Holds the configuration registers and the file walk state; each accepted
// byte updates the state and yields at most one result record.
// ----------------------------------------------------------------------------
module smf_parse (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           accept,
	input  logic [7:0]                     data_byte,
	input  logic                           last_of_file,
	output logic                           res_valid,
	output smf_pkg::res_t                  res
);
	import smf_pkg::*;

	logic [2:0]  capture_mask_q;
	logic        first_only_q;

	phase_t      phase_q, phase_d;
	logic [3:0]  hdr_cnt_q, hdr_cnt_d;
	logic [15:0] tracks_q, tracks_d;
	logic [2:0]  chunk_cnt_q, chunk_cnt_d;
	logic [31:0] tbl_q, tbl_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0]  rs_q, rs_d;
	logic [31:0] skip_q, skip_d;
	logic [7:0]  mtype_q, mtype_d;
	logic [2:0]  seen_q, seen_d;
	logic [1:0]  stop_q, stop_d;

	logic        emit;
	logic        lastev;
	kind_t       kind;
	cause_t      cause;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_mask_q <= 3'd7;
			first_only_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAPTURE_MASK: capture_mask_q <= cfg_data[2:0];
				CFG_FIRST_ONLY:   first_only_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [31:0] tbl_m1;
		logic [31:0] acc_sh;
		logic [31:0] tbl_new;
		logic [31:0] skip_dec;
		logic [15:0] tracks_dec;
		logic [1:0]  n;
		logic [2:0]  bit_k;
		logic        cap;
		kind_t       k;

		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		tracks_d    = tracks_q;
		chunk_cnt_d = chunk_cnt_q;
		tbl_d       = tbl_q;
		acc_d       = acc_q;
		rs_d        = rs_q;
		skip_d      = skip_q;
		mtype_d     = mtype_q;
		seen_d      = seen_q;
		stop_d      = stop_q;
		emit        = 1'b0;
		lastev      = 1'b0;
		kind        = KIND_TEXT;
		cause       = CAUSE_OK;

		tbl_m1     = tbl_q - 32'd1;
		acc_sh     = {acc_q[24:0], data_byte[6:0]};
		tracks_dec = tracks_q - 16'd1;
		skip_dec   = skip_q - 32'd1;
		tbl_new    = tbl_q;
		n          = 2'd0;
		bit_k      = 3'd0;
		cap        = 1'b0;
		k          = kind_of(mtype_q);

		if (accept) begin
			case (phase_q)
				PH_HDR: begin
					if (hdr_cnt_q < 4'd4 && data_byte != file_magic(hdr_cnt_q[1:0])) begin
						stop_d  = CAUSE_BAD_HDR;
						phase_d = PH_HALT;
					end else begin
						if (hdr_cnt_q == 4'd10) begin
							tracks_d = {data_byte, 8'h00};
						end else if (hdr_cnt_q == 4'd11) begin
							tracks_d = {tracks_q[15:8], data_byte};
						end
						hdr_cnt_d = hdr_cnt_q + 4'd1;
						if (hdr_cnt_d == HDR_LEN) begin
							chunk_cnt_d = 3'd0;
							phase_d = (tracks_q == 16'd0) ? PH_DONE : PH_CHDR;
						end
					end
				end
				PH_CHDR: begin
					if (chunk_cnt_q < 3'd4 && data_byte != trk_magic(chunk_cnt_q[1:0])) begin
						stop_d  = CAUSE_NOT_MTRK;
						phase_d = PH_HALT;
					end else begin
						if (chunk_cnt_q == 3'd4) begin
							tbl_new = {24'd0, data_byte};
						end else if (chunk_cnt_q > 3'd4) begin
							tbl_new = {tbl_q[23:0], data_byte};
						end
						tbl_d = tbl_new;
						if (chunk_cnt_q == 3'd7) begin
							chunk_cnt_d = 3'd0;
							if (tbl_new == 32'd0) begin
								tracks_d = tracks_dec;
								phase_d  = (tracks_dec == 16'd0) ? PH_DONE : PH_CHDR;
							end else begin
								rs_d    = 8'd0;
								acc_d   = 32'd0;
								phase_d = PH_DELTA;
							end
						end else begin
							chunk_cnt_d = chunk_cnt_q + 3'd1;
						end
					end
				end
				PH_DELTA, PH_STATUS, PH_MTYPE, PH_MLEN,
				PH_SXLEN, PH_SKIP, PH_EMIT, PH_TOEND: begin
					case (phase_q)
						PH_DELTA: begin
							acc_d = acc_sh;
							if (!data_byte[7]) begin
								phase_d = PH_STATUS;
							end
						end
						PH_STATUS: begin
							if (data_byte == STATUS_META) begin
								phase_d = PH_MTYPE;
							end else if (data_byte == STATUS_SYSEX ||
							             data_byte == STATUS_ESCAPE) begin
								acc_d   = 32'd0;
								phase_d = PH_SXLEN;
							end else begin
								if (data_byte[7]) begin
									rs_d = data_byte;
									n    = data_count(data_byte);
								end else begin
									n = data_count(rs_q) - 2'd1;
								end
								if (n != 2'd0) begin
									skip_d  = {30'd0, n};
									phase_d = PH_SKIP;
								end else begin
									acc_d   = 32'd0;
									phase_d = PH_DELTA;
								end
							end
						end
						PH_MTYPE: begin
							mtype_d = data_byte;
							acc_d   = 32'd0;
							phase_d = PH_MLEN;
						end
						PH_MLEN: begin
							acc_d = acc_sh;
							if (!data_byte[7]) begin
								if (mtype_q == META_EOT || acc_sh > tbl_m1) begin
									phase_d = PH_TOEND;
								end else if (acc_sh == 32'd0) begin
									acc_d   = 32'd0;
									phase_d = PH_DELTA;
								end else begin
									if (k != KIND_NONE) begin
										bit_k  = 3'd1 << k;
										cap    = (capture_mask_q & bit_k) != 3'd0 &&
										         !(first_only_q && (seen_q & bit_k) != 3'd0);
										seen_d = seen_q | bit_k;
									end
									skip_d  = acc_sh;
									phase_d = cap ? PH_EMIT : PH_SKIP;
								end
							end
						end
						PH_SXLEN: begin
							acc_d = acc_sh;
							if (!data_byte[7]) begin
								if (acc_sh == 32'd0) begin
									acc_d   = 32'd0;
									phase_d = PH_DELTA;
								end else begin
									skip_d  = acc_sh;
									phase_d = PH_SKIP;
								end
							end
						end
						PH_SKIP: begin
							skip_d = skip_dec;
							if (skip_dec == 32'd0) begin
								acc_d   = 32'd0;
								phase_d = PH_DELTA;
							end
						end
						PH_EMIT: begin
							emit   = 1'b1;
							kind   = k;
							skip_d = skip_dec;
							lastev = (skip_dec == 32'd0);
							if (skip_dec == 32'd0) begin
								acc_d   = 32'd0;
								phase_d = PH_DELTA;
							end
						end
						default: ;
					endcase
					tbl_d = tbl_m1;
					if (tbl_m1 == 32'd0) begin
						tracks_d    = tracks_dec;
						chunk_cnt_d = 3'd0;
						phase_d     = (tracks_dec == 16'd0) ? PH_DONE : PH_CHDR;
					end
				end
				default: ;
			endcase

			if (last_of_file) begin
				if (stop_d != CAUSE_OK) begin
					cause = cause_t'(stop_d);
				end else begin
					case (phase_d)
						PH_HDR:  cause = CAUSE_BAD_HDR;
						PH_CHDR: cause = (chunk_cnt_d != 3'd0) ? CAUSE_TRUNCATED : CAUSE_OK;
						PH_DONE, PH_HALT: cause = CAUSE_OK;
						default: cause = CAUSE_TRUNCATED;
					endcase
				end
				// The next byte starts a fresh file; configuration is kept.
				phase_d     = PH_HDR;
				hdr_cnt_d   = 4'd0;
				tracks_d    = 16'd0;
				chunk_cnt_d = 3'd0;
				tbl_d       = 32'd0;
				acc_d       = 32'd0;
				rs_d        = 8'd0;
				skip_d      = 32'd0;
				mtype_d     = 8'd0;
				seen_d      = 3'd0;
				stop_d      = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			hdr_cnt_q   <= 4'd0;
			tracks_q    <= 16'd0;
			chunk_cnt_q <= 3'd0;
			tbl_q       <= 32'd0;
			acc_q       <= 32'd0;
			rs_q        <= 8'd0;
			skip_q      <= 32'd0;
			mtype_q     <= 8'd0;
			seen_q      <= 3'd0;
			stop_q      <= 2'd0;
		end else begin
			phase_q     <= phase_d;
			hdr_cnt_q   <= hdr_cnt_d;
			tracks_q    <= tracks_d;
			chunk_cnt_q <= chunk_cnt_d;
			tbl_q       <= tbl_d;
			acc_q       <= acc_d;
			rs_q        <= rs_d;
			skip_q      <= skip_d;
			mtype_q     <= mtype_d;
			seen_q      <= seen_d;
			stop_q      <= stop_d;
		end
	end

	always_comb begin
		res_valid         = accept && (emit || last_of_file);
		res.payload_valid = emit;
		res.meta_kind     = emit ? kind : KIND_TEXT;
		res.payload_byte  = emit ? data_byte : 8'd0;
		res.last_of_event = emit && lastev;
		res.file_done     = last_of_file;
		res.stop_cause    = cause;
	end

endmodule

// ----- sv/smf_out_reg.sv -----
// ----------------------------------------------------------------------------
// smf_out_reg: result register toward the receiver
// Holds one finished result item and frees itself in the cycle the
// receiver takes it, so a new input byte can enter at the same edge.
// ----------------------------------------------------------------------------
module smf_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  smf_pkg::res_t res,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output smf_pkg::res_t res_q
);
	import smf_pkg::*;

	logic valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- sv/smf_meta_text_extractor.sv -----
// ----------------------------------------------------------------------------
// smf_meta_text_extractor: Standard MIDI File meta text extractor
// Walks a MIDI file byte by byte and passes out captured text, track name
// and marker payload bytes, plus a done report on the last file byte.
// ----------------------------------------------------------------------------
// Usage: file bytes enter on in_valid/in_ready with data_byte and
// last_of_file; each byte is parsed in the cycle it is accepted. A byte
// gives a result item only when it is a captured payload byte or the last
// byte of the file; all other bytes are absorbed silently.
// The result for a byte is on out_valid the cycle after the byte is
// accepted. The block takes one byte per cycle while in_ready stays high,
// as the parse state is updated combinationally for each accepted byte.
// The output register frees itself in the cycle the receiver takes the
// item, so in_ready stays high while the receiver keeps up. When the
// receiver stalls with a result held, in_ready drops until it is taken.
// Reset clears the parse state, sets capture_mask to 7 and first_only to 1,
// and empties the output register. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at once and belong in idle periods. After the last
// byte of a file the parse state restarts for the next file.
// ----------------------------------------------------------------------------
module smf_meta_text_extractor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           last_of_file,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           payload_valid,
	output logic [1:0]                     meta_kind,
	output logic [7:0]                     payload_byte,
	output logic                           last_of_event,
	output logic                           file_done,
	output logic [1:0]                     stop_cause
);
	import smf_pkg::*;

	logic accept;
	logic res_valid;
	res_t res;
	res_t res_q;

	assign accept = in_valid && in_ready;

	smf_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.data_byte    (data_byte),
		.last_of_file (last_of_file),
		.res_valid    (res_valid),
		.res          (res)
	);

	smf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.free      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign payload_valid = res_q.payload_valid;
	assign meta_kind     = res_q.meta_kind;
	assign payload_byte  = res_q.payload_byte;
	assign last_of_event = res_q.last_of_event;
	assign file_done     = res_q.file_done;
	assign stop_cause    = res_q.stop_cause;

endmodule

// ----- sv/smf_chk.sv -----
// ----------------------------------------------------------------------------
// smf_chk: port-level checks for the meta text extractor
// Watches the result channel of the top level and is attached by bind.
// ----------------------------------------------------------------------------
module smf_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       payload_valid,
	input logic [1:0] meta_kind,
	input logic [7:0] payload_byte,
	input logic       last_of_event,
	input logic       file_done,
	input logic [1:0] stop_cause
);
	import smf_pkg::*;

	// A stalled result item must stay offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// Every item carries a payload byte or reports the end of the file.
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> payload_valid || file_done)
		else $error("result item with neither payload nor file end");

	// A stop cause is only reported with the file end.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !file_done |-> stop_cause == CAUSE_OK)
		else $error("stop cause without file end");

	// Payload fields are zero on an item without payload.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |->
			meta_kind == KIND_TEXT && payload_byte == 8'd0 && !last_of_event)
		else $error("payload fields set on an item without payload");

	// Captured bytes always belong to one of the three text kinds.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> meta_kind != KIND_NONE)
		else $error("payload byte with an unknown kind");

endmodule

bind smf_meta_text_extractor smf_chk u_smf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.payload_valid (payload_valid),
	.meta_kind     (meta_kind),
	.payload_byte  (payload_byte),
	.last_of_event (last_of_event),
	.file_done     (file_done),
	.stop_cause    (stop_cause)
);

// ----- tb/sv/smf_text_checker.sv -----
// ----------------------------------------------------------------------------
// smf_text_checker: result predictor and checker for the MIDI text extractor
// Watches the byte and result channels of the extractor. Every accepted byte
// is run through a cycle-free model of the file walker, and every result
// that it predicts is queued. Accepted result items are then compared with
// the oldest queued one. The mismatch count and the number of results still
// owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module smf_text_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           last_of_file,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           payload_valid,
	input  logic [1:0]                     meta_kind,
	input  logic [7:0]                     payload_byte,
	input  logic                           last_of_event,
	input  logic                           file_done,
	input  logic [1:0]                     stop_cause,
	output int                             fail_count,
	output int                             results_owed
);

	timeunit 1ns;
	timeprecision 1ps;

	import smf_pkg::*;

	localparam logic [7:0] FILE_ID [4]  = '{8'h4D, 8'h54, 8'h68, 8'h64};
	localparam logic [7:0] TRACK_ID [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

	// Configuration copy.
	logic [2:0]  cap_mask;
	logic        first_only_r;

	// Parse state of the model.
	phase_t      parse_ph;
	logic [3:0]  hdr_cnt;
	logic [15:0] trk_remaining;
	logic [2:0]  chdr_cnt;
	logic [31:0] chunk_left;
	logic [31:0] vlq;
	logic [7:0]  run_status;
	logic [31:0] skip_left;
	logic [7:0]  meta_type;
	logic [2:0]  seen_kinds;
	cause_t      halt_cause;

	res_t        text_results_q[$];
	int          mism_total;

	function automatic logic [1:0] chan_data_len(input logic [7:0] s);
		return (s[7:5] == 3'b110) ? 2'd1 : 2'd2;
	endfunction

	function automatic kind_t text_kind(input logic [7:0] mtype);
		kind_t k;
		k = KIND_NONE;
		if (mtype == META_TEXT) begin
			k = KIND_TEXT;
		end else if (mtype == META_NAME) begin
			k = KIND_NAME;
		end else if (mtype == META_MARKER) begin
			k = KIND_MARKER;
		end
		return k;
	endfunction

	function automatic string res_str(input res_t r);
		return $sformatf("v=%0d kind=%0d byte=%02h eoe=%0d done=%0d cause=%0d",
			r.payload_valid, r.meta_kind, r.payload_byte, r.last_of_event,
			r.file_done, r.stop_cause);
	endfunction

	task automatic clear_parse_state();
		parse_ph = PH_HDR;
		hdr_cnt = '0;
		trk_remaining = '0;
		chdr_cnt = '0;
		chunk_left = '0;
		vlq = '0;
		run_status = '0;
		skip_left = '0;
		meta_type = '0;
		seen_kinds = '0;
		halt_cause = CAUSE_OK;
	endtask

	task automatic restart_delta();
		vlq = '0;
		parse_ph = PH_DELTA;
	endtask

	task automatic close_track();
		trk_remaining = trk_remaining - 16'd1;
		chdr_cnt = '0;
		if (trk_remaining == 16'd0) begin
			parse_ph = PH_DONE;
		end else begin
			parse_ph = PH_CHDR;
		end
	endtask

	// One byte inside a track chunk body.
	task automatic track_byte(input logic [7:0] b, output logic emit, output kind_t kind,
			output logic ev_end);
		logic [1:0] dlen;
		logic [2:0] kbit;
		logic       cap;
		kind_t      k;
		emit = 1'b0;
		kind = KIND_TEXT;
		ev_end = 1'b0;
		case (parse_ph)
			PH_DELTA: begin
				vlq = {vlq[24:0], b[6:0]};
				if (!b[7]) begin
					parse_ph = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (b == STATUS_META) begin
					parse_ph = PH_MTYPE;
				end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
					vlq = '0;
					parse_ph = PH_SXLEN;
				end else begin
					// A data byte here is the first data byte under running status.
					if (b[7]) begin
						run_status = b;
						dlen = chan_data_len(b);
					end else begin
						dlen = chan_data_len(run_status) - 2'd1;
					end
					if (dlen != 2'd0) begin
						skip_left = {30'd0, dlen};
						parse_ph = PH_SKIP;
					end else begin
						restart_delta();
					end
				end
			end
			PH_MTYPE: begin
				meta_type = b;
				vlq = '0;
				parse_ph = PH_MLEN;
			end
			PH_MLEN: begin
				vlq = {vlq[24:0], b[6:0]};
				if (!b[7]) begin
					if (meta_type == META_EOT || vlq > chunk_left - 32'd1) begin
						parse_ph = PH_TOEND;
					end else if (vlq == 32'd0) begin
						restart_delta();
					end else begin
						k = text_kind(meta_type);
						cap = 1'b0;
						if (k != KIND_NONE) begin
							kbit = 3'b001 << k;
							cap = (cap_mask & kbit) != 3'd0 &&
								!(first_only_r && (seen_kinds & kbit) != 3'd0);
							seen_kinds = seen_kinds | kbit;
						end
						skip_left = vlq;
						if (cap) begin
							parse_ph = PH_EMIT;
						end else begin
							parse_ph = PH_SKIP;
						end
					end
				end
			end
			PH_SXLEN: begin
				vlq = {vlq[24:0], b[6:0]};
				if (!b[7]) begin
					if (vlq == 32'd0) begin
						restart_delta();
					end else begin
						skip_left = vlq;
						parse_ph = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				skip_left = skip_left - 32'd1;
				if (skip_left == 32'd0) begin
					restart_delta();
				end
			end
			PH_EMIT: begin
				emit = 1'b1;
				kind = text_kind(meta_type);
				skip_left = skip_left - 32'd1;
				ev_end = (skip_left == 32'd0);
				if (ev_end) begin
					restart_delta();
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic parse_file_byte(input logic [7:0] b, input logic last,
			output logic has_res, output res_t r);
		logic   emit;
		logic   ev_end;
		kind_t  kind;
		cause_t cause;
		emit = 1'b0;
		ev_end = 1'b0;
		kind = KIND_TEXT;
		cause = CAUSE_OK;
		case (parse_ph)
			PH_HDR: begin
				if (hdr_cnt < 4'd4 && b != FILE_ID[hdr_cnt[1:0]]) begin
					halt_cause = CAUSE_BAD_HDR;
					parse_ph = PH_HALT;
				end else begin
					if (hdr_cnt == 4'd10) begin
						trk_remaining = {b, 8'h00};
					end else if (hdr_cnt == 4'd11) begin
						trk_remaining[7:0] = b;
					end
					hdr_cnt = hdr_cnt + 4'd1;
					if (hdr_cnt >= HDR_LEN) begin
						chdr_cnt = '0;
						if (trk_remaining == 16'd0) begin
							parse_ph = PH_DONE;
						end else begin
							parse_ph = PH_CHDR;
						end
					end
				end
			end
			PH_CHDR: begin
				if (chdr_cnt < 3'd4 && b != TRACK_ID[chdr_cnt[1:0]]) begin
					halt_cause = CAUSE_NOT_MTRK;
					parse_ph = PH_HALT;
				end else begin
					if (chdr_cnt == 3'd4) begin
						chunk_left = {24'd0, b};
					end else if (chdr_cnt > 3'd4) begin
						chunk_left = {chunk_left[23:0], b};
					end
					if (chdr_cnt == 3'd7) begin
						chdr_cnt = '0;
						if (chunk_left == 32'd0) begin
							close_track();
						end else begin
							run_status = '0;
							restart_delta();
						end
					end else begin
						chdr_cnt = chdr_cnt + 3'd1;
					end
				end
			end
			PH_DONE, PH_HALT: begin
			end
			default: begin
				track_byte(b, emit, kind, ev_end);
				chunk_left = chunk_left - 32'd1;
				if (chunk_left == 32'd0) begin
					close_track();
				end
			end
		endcase

		has_res = emit || last;
		r = '0;
		if (emit) begin
			r.payload_valid = 1'b1;
			r.meta_kind = kind;
			r.payload_byte = b;
			r.last_of_event = ev_end;
		end
		if (last) begin
			if (halt_cause != CAUSE_OK) begin
				cause = halt_cause;
			end else if (parse_ph == PH_HDR) begin
				cause = CAUSE_BAD_HDR;
			end else if (parse_ph == PH_CHDR) begin
				// Ending cleanly between chunks is fine even with tracks left.
				cause = (chdr_cnt != 3'd0) ? CAUSE_TRUNCATED : CAUSE_OK;
			end else if (parse_ph == PH_DONE || parse_ph == PH_HALT) begin
				cause = CAUSE_OK;
			end else begin
				cause = CAUSE_TRUNCATED;
			end
			r.file_done = 1'b1;
			r.stop_cause = cause;
			clear_parse_state();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t  got;
		res_t  want;
		res_t  next_res;
		logic  has_res;
		if (!arst_n) begin
			cap_mask = 3'd7;
			first_only_r = 1'b1;
			clear_parse_state();
			text_results_q.delete();
			mism_total = 0;
			fail_count <= 0;
			results_owed <= 0;
		end else begin
			// Compare first so that a stray result never meets this edge's prediction.
			if (out_valid && out_ready) begin
				got.payload_valid = payload_valid;
				got.meta_kind = meta_kind;
				got.payload_byte = payload_byte;
				got.last_of_event = last_of_event;
				got.file_done = file_done;
				got.stop_cause = stop_cause;
				if (text_results_q.size() == 0) begin
					if (mism_total < 10) begin
						$display("%0t: result item with none expected: %s",
							$time, res_str(got));
					end
					mism_total++;
				end else begin
					want = text_results_q.pop_front();
					if (got.payload_valid !== want.payload_valid ||
							got.meta_kind !== want.meta_kind ||
							got.payload_byte !== want.payload_byte ||
							got.last_of_event !== want.last_of_event ||
							got.file_done !== want.file_done ||
							got.stop_cause !== want.stop_cause) begin
						if (mism_total < 10) begin
							$display("%0t: result mismatch: expected %s",
								$time, res_str(want));
							$display("%0t:                    actual %s",
								$time, res_str(got));
						end
						mism_total++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_CAPTURE_MASK) begin
					cap_mask = cfg_data[2:0];
				end else if (cfg_index == CFG_FIRST_ONLY) begin
					first_only_r = cfg_data[0];
				end
			end
			if (in_valid && in_ready) begin
				parse_file_byte(data_byte, last_of_file, has_res, next_res);
				if (has_res) begin
					text_results_q.insert(text_results_q.size(), next_res);
				end
			end
			fail_count <= mism_total;
			results_owed <= text_results_q.size();
		end
	end

endmodule

// ----- tb/sv/tb_smf_meta_text_extractor.sv -----
// ----------------------------------------------------------------------------
// tb_smf_meta_text_extractor: testbench top for the MIDI meta text extractor
// Feeds whole MIDI files byte by byte: a few short broken files first, then
// random files under several capture settings. Most files are well formed
// with random events; the rest have bad ids, wrong counts, trailing bytes or are cut short.
// Both channels idle at random, and the receiver holds off once for a long
// stretch. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_smf_meta_text_extractor;

	timeunit 1ns;
	timeprecision 1ps;

	import smf_pkg::*;

	localparam int unsigned N_PLANS         = 6;
	localparam int unsigned BYTES_PER_PLAN  = 270;
	localparam logic [2:0]  MASK_PLAN [5]   = '{3'd7, 3'd0, 3'd7, 3'd5, 3'd2};
	localparam logic        FIRST_PLAN [5]  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
	localparam logic [7:0]  FILE_TAG [4]    = '{8'h4D, 8'h54, 8'h68, 8'h64};
	localparam logic [7:0]  TRACK_TAG [4]   = '{8'h4D, 8'h54, 8'h72, 8'h6B};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            data_byte = '0;
	logic                  last_of_file = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  payload_valid;
	logic [1:0]            meta_kind;
	logic [7:0]            payload_byte;
	logic                  last_of_event;
	logic                  file_done;
	logic [1:0]            stop_cause;

	int                    fail_count;
	int                    results_owed;

	logic [7:0]            file_bytes[$];
	logic [7:0]            track_body[$];
	logic [7:0]            gen_status;
	logic                  tx_calm = 1'b0;
	logic                  hold_req = 1'b0;
	int unsigned           bytes_sent = 0;

	smf_meta_text_extractor i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_of_file  (last_of_file),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_valid (payload_valid),
		.meta_kind     (meta_kind),
		.payload_byte  (payload_byte),
		.last_of_event (last_of_event),
		.file_done     (file_done),
		.stop_cause    (stop_cause)
	);

	smf_text_checker i_text_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_of_file  (last_of_file),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_valid (payload_valid),
		.meta_kind     (meta_kind),
		.payload_byte  (payload_byte),
		.last_of_event (last_of_event),
		.file_done     (file_done),
		.stop_cause    (stop_cause),
		.fail_count    (fail_count),
		.results_owed  (results_owed)
	);

	initial begin
		forever begin
			#10 clk = ~clk;
		end
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Append one byte to the track body or to the file image.
	function automatic void body_add(input logic [7:0] b);
		track_body.insert(track_body.size(), b);
	endfunction

	function automatic void file_add(input logic [7:0] b);
		file_bytes.insert(file_bytes.size(), b);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (tx_calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [1:0] chan_len(input logic [7:0] s);
		return (s[7:5] == 3'b110) ? 2'd1 : 2'd2;
	endfunction

	// Called at a clock edge; returns at the edge where the item is taken.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_of_file <= last;
		do begin
			@(posedge clk);
		end while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_file();
		tx_calm = ($urandom_range(0, 3) == 0);
		foreach (file_bytes[i]) begin
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		end
	endtask

	// Wait until every predicted result has been taken, then idle a while.
	task automatic settle();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (results_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [2:0] mask, input logic first);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CAPTURE_MASK;
		cfg_data <= mask;
		@(posedge clk);
		cfg_index <= CFG_FIRST_ONLY;
		cfg_data <= {2'b00, first};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Variable-length number; pad adds redundant leading zero groups.
	task automatic body_varlen(input logic [31:0] v, input int unsigned pad);
		logic [7:0] grp[$];
		grp.push_front({1'b0, v[6:0]});
		v = v >> 7;
		while (v != 0) begin
			grp.push_front({1'b1, v[6:0]});
			v = v >> 7;
		end
		repeat (pad) grp.push_front(8'h80);
		foreach (grp[i]) begin
			body_add(grp[i]);
		end
	endtask

	task automatic add_event();
		int unsigned r;
		int unsigned n;
		int unsigned pad;
		logic [31:0] delta;
		logic [7:0]  st;
		delta = ($urandom_range(0, 3) == 0) ? $urandom_range(128, 32'h0FFF_FFFF)
			: $urandom_range(0, 127);
		pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
		body_varlen(delta, pad);
		r = $urandom_range(0, 99);
		if (r < 32) begin
			case ($urandom_range(0, 2))
				0: st = META_TEXT;
				1: st = META_NAME;
				default: st = META_MARKER;
			endcase
			n = $urandom_range(0, 99);
			if (n < 10) begin
				n = 0;
			end else if (n < 90) begin
				n = $urandom_range(1, 8);
			end else begin
				n = $urandom_range(9, 40);
			end
			body_add(STATUS_META);
			body_add(st);
			body_varlen(n, ($urandom_range(0, 7) == 0) ? 1 : 0);
			repeat (n) body_add(8'($urandom_range(0, 255)));
		end else if (r < 40) begin
			n = $urandom_range(0, 5);
			body_add(STATUS_META);
			body_add(8'($urandom_range(0, 255)));
			body_varlen(n, 0);
			repeat (n) body_add(8'($urandom_range(0, 255)));
		end else if (r < 60) begin
			st = 8'($urandom_range(8'h80, 8'hEF));
			gen_status = st;
			body_add(st);
			repeat (chan_len(st)) body_add(8'($urandom_range(0, 127)));
		end else if (r < 72) begin
			repeat (chan_len(gen_status)) body_add(8'($urandom_range(0, 127)));
		end else if (r < 81) begin
			n = $urandom_range(0, 6);
			body_add($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE);
			body_varlen(n, 0);
			repeat (n) body_add(8'($urandom_range(0, 255)));
		end else if (r < 87) begin
			// System status bytes other than sysex and meta act as running status.
			do begin
				st = 8'($urandom_range(8'hF1, 8'hFE));
			end while (st == STATUS_ESCAPE);
			gen_status = st;
			body_add(st);
			repeat (2) body_add(8'($urandom_range(0, 127)));
		end else if (r < 96) begin
			body_add(8'($urandom_range(0, 255)));
		end else begin
			// Meta length that runs past the chunk end.
			body_add(STATUS_META);
			body_add($urandom_range(0, 1) ? META_TEXT : META_MARKER);
			body_varlen($urandom_range(300, 100_000), 0);
		end
	endtask

	task automatic add_track();
		int unsigned n_ev;
		logic [31:0] len;
		track_body.delete();
		gen_status = '0;
		n_ev = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
		repeat (n_ev) add_event();
		if (n_ev != 0 && $urandom_range(0, 99) < 60) begin
			body_add(8'h00);
			body_add(STATUS_META);
			body_add(META_EOT);
			body_add(8'h00);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) body_add(8'($urandom_range(0, 255)));
			end
		end
		len = track_body.size();
		// Sometimes the chunk is declared shorter and its body cut to match, which can cut its last events.
		if (len != 0 && $urandom_range(0, 99) < 8) begin
			len = $urandom_range(0, len - 1);
			while (track_body.size() > len) begin
				track_body.delete(track_body.size() - 1);
			end
		end
		foreach (TRACK_TAG[i]) begin
			file_add(TRACK_TAG[i]);
		end
		file_add(len[31:24]);
		file_add(len[23:16]);
		file_add(len[15:8]);
		file_add(len[7:0]);
		foreach (track_body[i]) begin
			file_add(track_body[i]);
		end
	endtask

	task automatic build_file();
		int unsigned n_trk;
		int unsigned r;
		int unsigned cut;
		logic [15:0] decl;
		file_bytes.delete();
		foreach (FILE_TAG[i]) begin
			file_add(FILE_TAG[i]);
		end
		repeat (6) file_add(8'($urandom_range(0, 255)));
		n_trk = $urandom_range(1, 3);
		r = $urandom_range(0, 99);
		if (r < 5) begin
			decl = '0;
		end else if (r < 10) begin
			decl = 16'($urandom_range(n_trk + 1, 16'hFFFF));
		end else if (r < 15) begin
			decl = 16'($urandom_range(1, n_trk));
		end else begin
			decl = 16'(n_trk);
		end
		file_add(decl[15:8]);
		file_add(decl[7:0]);
		repeat (2) file_add(8'($urandom_range(0, 255)));
		repeat (n_trk) add_track();

		r = $urandom_range(0, 99);
		if (r < 5) begin
			file_bytes[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
		end else if (r < 10) begin
			file_bytes[14 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
		end else if (r < 18) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > cut) begin
				file_bytes.delete(file_bytes.size() - 1);
			end
		end else if (r < 23) begin
			repeat ($urandom_range(1, 10)) file_add(8'($urandom_range(0, 255)));
		end
	endtask

	// Receiver side: random stalls, calm stretches and one long hold-off.
	initial begin
		int unsigned stall_left;
		int unsigned calm_left;
		int unsigned r;
		logic        hold_done;
		stall_left = 0;
		calm_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall_left = 500;
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (calm_left != 0) begin
					calm_left--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 5) begin
						calm_left = $urandom_range(20, 80);
					end else if (r >= 95) begin
						stall_left = $urandom_range(8, 40);
					end else if (r >= 70) begin
						stall_left = $urandom_range(1, 3);
					end
				end
			end
		end
	end

	initial begin
		logic [2:0]  mask;
		logic        first;
		int unsigned plan_start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short files under the reset settings: wrong id byte, header cut
		// short, and a file with no tracks followed by a stray byte.
		file_bytes = '{8'h4D, 8'h54, 8'hFF};
		send_file();
		file_bytes = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00};
		send_file();
		file_bytes = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
		send_file();

		for (int p = 0; p < N_PLANS; p++) begin
			settle();
			if (p < 5) begin
				mask = MASK_PLAN[p];
				first = FIRST_PLAN[p];
			end else begin
				mask = 3'($urandom_range(0, 7));
				first = 1'($urandom_range(0, 1));
			end
			write_cfg(mask, first);
			if (p == 1) begin
				hold_req <= 1'b1;
			end
			plan_start = bytes_sent;
			while (bytes_sent - plan_start < BYTES_PER_PLAN) begin
				build_file();
				send_file();
			end
		end
		settle();

		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- smf_meta_text_extractor.f -----
sv/smf_pkg.sv
sv/smf_parse.sv
sv/smf_out_reg.sv
sv/smf_meta_text_extractor.sv
sv/smf_chk.sv
tb/sv/smf_text_checker.sv
tb/sv/tb_smf_meta_text_extractor.sv
